>>> src/rpsm_pkg.sv
// Shared types, constants and table functions for the RTSP payload signature matcher.
// Used by the matcher step logic and the top level; depends on nothing else.

package rpsm_pkg;

	localparam int NUM_WORDS  = 12;
	localparam int WORD_MAX   = 14;
	localparam int WORD_IDX_W = 4;
	localparam int POS_W      = 4;
	localparam int PROG_W     = 4;

	// Word indexes with a special role; all the others are bare method names.
	localparam logic [WORD_IDX_W-1:0] WORD_TEARDOWN = 4'd10;
	localparam logic [WORD_IDX_W-1:0] WORD_RESPONSE = 4'd11;

	// Progress marks inside the TEARDOWN version search.
	localparam logic [PROG_W-1:0] TD_LIT_DONE = 4'd6;
	localparam logic [PROG_W-1:0] TD_MAJOR    = 4'd7;
	localparam logic [PROG_W-1:0] TD_MINOR    = 4'd8;

	typedef enum logic [1:0] {
		MODE_PREFIX,
		MODE_TEARDOWN,
		MODE_RESPONSE
	} mode_t;

	typedef struct packed {
		mode_t                  mode;
		logic [POS_W-1:0]       pos;
		logic [NUM_WORDS-1:0]   alive;
		logic [PROG_W-1:0]      prog;
		logic [1:0]             dwin;
		logic                   ended;
		logic                   matched;
		logic                   rejected;
	} match_state_t;

	localparam match_state_t STATE_INIT = '{
		mode:     MODE_PREFIX,
		pos:      '0,
		alive:    '1,
		prog:     '0,
		dwin:     '0,
		ended:    1'b0,
		matched:  1'b0,
		rejected: 1'b0
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic [POS_W-1:0] word_len(input logic [WORD_IDX_W-1:0] w);
		logic [POS_W-1:0] len;
		unique case (w)
			4'd0:    len = 4'd8;
			4'd1:    len = 4'd8;
			4'd2:    len = 4'd13;
			4'd3:    len = 4'd7;
			4'd4:    len = 4'd5;
			4'd5:    len = 4'd4;
			4'd6:    len = 4'd6;
			4'd7:    len = 4'd8;
			4'd8:    len = 4'd5;
			4'd9:    len = 4'd13;
			4'd10:   len = 4'd9;
			4'd11:   len = 4'd5;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	// Character at position pos of word w. The literal sits right-justified in
	// txt, so it is first moved up against the top byte.
	function automatic logic [7:0] word_char(input logic [WORD_IDX_W-1:0] w,
			input logic [POS_W-1:0] pos);
		logic [WORD_MAX*8-1:0] txt;
		logic [WORD_MAX*8-1:0] sh;
		logic [POS_W:0]        amt;
		unique case (w)
			4'd0:    txt = (WORD_MAX*8)'("DESCRIBE");
			4'd1:    txt = (WORD_MAX*8)'("ANNOUNCE");
			4'd2:    txt = (WORD_MAX*8)'({"GET_", "PARAMETER"});
			4'd3:    txt = (WORD_MAX*8)'("OPTIONS");
			4'd4:    txt = (WORD_MAX*8)'("PAUSE");
			4'd5:    txt = (WORD_MAX*8)'("PLAY");
			4'd6:    txt = (WORD_MAX*8)'("RECORD");
			4'd7:    txt = (WORD_MAX*8)'("REDIRECT");
			4'd8:    txt = (WORD_MAX*8)'("SETUP");
			4'd9:    txt = (WORD_MAX*8)'({"SET_", "PARAMETER"});
			4'd10:   txt = (WORD_MAX*8)'("TEARDOWN ");
			4'd11:   txt = (WORD_MAX*8)'("RTSP/");
			default: txt = '0;
		endcase
		amt = (POS_W+1)'(WORD_MAX) - {1'b0, word_len(w)} + {1'b0, pos};
		sh  = txt << {amt, 3'b000};
		return sh[WORD_MAX*8-1 -: 8];
	endfunction

	// The literal " RTSP/" searched for after TEARDOWN.
	function automatic logic [7:0] rtsp_char(input logic [2:0] s);
		logic [7:0] ch;
		unique case (s)
			3'd0:    ch = " ";
			3'd1:    ch = "R";
			3'd2:    ch = "T";
			3'd3:    ch = "S";
			3'd4:    ch = "P";
			3'd5:    ch = "/";
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

>>> src/rpsm_in_if.sv
// Input channel of the signature matcher: one payload byte per beat.
// Stand-alone valid/ready interface; no dependencies.

interface rpsm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       last_byte;
	logic       empty_payload;

	modport source (output valid, payload_byte, last_byte, empty_payload, input ready);
	modport sink   (input valid, payload_byte, last_byte, empty_payload, output ready);
endinterface

>>> src/rpsm_out_if.sv
// Output channel of the signature matcher: one verdict per beat.
// Stand-alone valid/ready interface; no dependencies.

interface rpsm_out_if;
	logic valid;
	logic ready;
	logic rtsp_match;

	modport source (output valid, rtsp_match, input ready);
	modport sink   (input valid, rtsp_match, output ready);
endinterface

>>> src/rpsm_step.sv
// Next-state logic of the signature DFA for one payload byte.
// Depends on rpsm_pkg for the state type and the word tables.

module rpsm_step import rpsm_pkg::*; (
	input  match_state_t cur,
	input  logic [7:0]   c,
	input  logic         tcp,
	output match_state_t nxt
);

	logic [NUM_WORDS-1:0]  hit;
	logic [WORD_IDX_W-1:0] first;
	logic [PROG_W-1:0]     restart;
	logic                  digit;

	assign digit   = is_digit(c);
	assign restart = (c == " ") ? PROG_W'(1) : '0;

	// A word stays alive while its prefix equals every byte seen so far.
	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			hit[w] = cur.alive[w]
				&& (cur.pos < word_len(WORD_IDX_W'(w)))
				&& (word_char(WORD_IDX_W'(w), cur.pos) == c);
		end
	end

	// Lowest-indexed surviving word decides completion.
	always_comb begin
		first = '0;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (hit[w]) begin
				first = WORD_IDX_W'(w);
			end
		end
	end

	always_comb begin
		nxt = cur;
		if (!(cur.ended || cur.matched || cur.rejected)) begin
			if (c == 8'h00) begin
				nxt.ended = 1'b1;
			end else begin
				unique case (cur.mode)
					MODE_PREFIX: begin
						if (hit == '0) begin
							nxt.rejected = 1'b1;
						end else begin
							nxt.alive = hit;
							nxt.pos   = cur.pos + POS_W'(1);
							if (cur.pos + POS_W'(1) == word_len(first)) begin
								nxt.prog = '0;
								nxt.dwin = '0;
								if (first == WORD_TEARDOWN) begin
									nxt.mode = MODE_TEARDOWN;
								end else if (first == WORD_RESPONSE) begin
									nxt.mode = MODE_RESPONSE;
								end else begin
									nxt.matched = 1'b1;
								end
							end
						end
					end
					MODE_TEARDOWN: begin
						if (cur.prog < TD_LIT_DONE) begin
							nxt.prog = (rtsp_char(cur.prog[2:0]) == c) ?
								cur.prog + PROG_W'(1) : restart;
						end else if (cur.prog == TD_LIT_DONE) begin
							nxt.prog = digit ? TD_MAJOR : restart;
						end else if (cur.prog == TD_MAJOR) begin
							if (c == ".") begin
								nxt.prog = TD_MINOR;
							end else if (!tcp && digit) begin
								nxt.prog = TD_MAJOR;
							end else begin
								nxt.prog = restart;
							end
						end else begin
							if (digit) begin
								nxt.matched = 1'b1;
							end else begin
								nxt.prog = restart;
							end
						end
					end
					MODE_RESPONSE: begin
						if (!tcp) begin
							// Strict form: version, space, status code, space.
							unique case (cur.prog)
								4'd0: begin
									if (digit) nxt.prog = 4'd1;
									else nxt.rejected = 1'b1;
								end
								4'd1: begin
									if (c == ".") nxt.prog = 4'd2;
									else if (!digit) nxt.rejected = 1'b1;
								end
								4'd2: begin
									if (digit) nxt.prog = 4'd3;
									else nxt.rejected = 1'b1;
								end
								4'd3: begin
									if (c == " ") nxt.prog = 4'd4;
									else if (!digit) nxt.rejected = 1'b1;
								end
								4'd4: begin
									if (c >= "1" && c <= "5") nxt.prog = 4'd5;
									else nxt.rejected = 1'b1;
								end
								4'd5: begin
									if (digit) nxt.prog = 4'd6;
									else nxt.rejected = 1'b1;
								end
								4'd6: begin
									if (digit) nxt.prog = 4'd7;
									else nxt.rejected = 1'b1;
								end
								default: begin
									if (c == " ") nxt.matched = 1'b1;
									else nxt.rejected = 1'b1;
								end
							endcase
						end else begin
							// Loose form: single-digit version, status code anywhere later.
							if (cur.prog == 4'd0) begin
								if (digit) nxt.prog = 4'd1;
								else nxt.rejected = 1'b1;
							end else if (cur.prog == 4'd1) begin
								if (c == ".") nxt.prog = 4'd2;
								else nxt.rejected = 1'b1;
							end else if (cur.prog == 4'd2) begin
								if (digit) begin
									nxt.prog = 4'd3;
									nxt.dwin = 2'd0;
								end else begin
									nxt.rejected = 1'b1;
								end
							end else begin
								if (cur.dwin == 2'd0) begin
									nxt.dwin = (c >= "1" && c <= "5") ? 2'd1 : 2'd0;
								end else if (cur.dwin == 2'd1) begin
									nxt.dwin = digit ? 2'd2 : 2'd0;
								end else begin
									if (digit) nxt.matched = 1'b1;
									else nxt.dwin = 2'd0;
								end
							end
						end
					end
					default: begin
						nxt.rejected = 1'b1;
					end
				endcase
			end
		end
	end

endmodule

>>> src/rtsp_payload_signature_matcher.sv
// A final beat passes the input stage, then the result register, where its verdict waits until taken.
// Throughput: one payload byte per cycle while the input is not stalled.
// The input stalls only while a final byte waits behind an unaccepted verdict.
// Reset (arst_n low, asynchronous) empties both stages, returns the DFA to the start
// of the anchored pattern and selects the UDP signature.
// Depends on rpsm_pkg, rpsm_in_if, rpsm_out_if and rpsm_step.

module rtsp_payload_signature_matcher import rpsm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rpsm_in_if.sink     payload,
	rpsm_out_if.source  verdict,
	input  logic        variant_we,
	input  logic        variant_wdata
);

	// Variant register: 0 selects the UDP signature, 1 the TCP signature.
	logic variant_q;

	// Input stage. The byte is captured here and fed to the DFA update in the
	// following cycle, so the update logic sees only registered inputs.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       empty_s1;

	// DFA state for the payload in progress.
	match_state_t state_q;
	match_state_t state_nxt;

	// Result register, decoupling the verdict consumer from the input side.
	logic out_valid_q;
	logic match_q;

	logic adv_s1;
	logic accept;

	// A non-final beat always moves on; a final beat needs room in the result
	// register, which is there when it is empty or being emptied this cycle.
	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign payload.ready = !valid_s1 || adv_s1;
	assign accept = payload.valid && payload.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (variant_we) begin
			variant_q <= variant_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= payload.payload_byte;
			last_s1  <= payload.last_byte;
			empty_s1 <= payload.empty_payload;
		end
	end

	rpsm_step u_step (
		.cur (state_q),
		.c   (byte_s1),
		.tcp (variant_q),
		.nxt (state_nxt)
	);

	// The state goes back to the start of the pattern after every verdict,
	// so consecutive payloads run back to back with no gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
		end else if (adv_s1) begin
			if (last_s1) begin
				state_q <= STATE_INIT;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// An empty payload never matches; otherwise the verdict includes the final byte.
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			match_q <= !empty_s1 && state_nxt.matched;
		end
	end

	assign verdict.valid      = out_valid_q;
	assign verdict.rtsp_match = match_q;

endmodule

>>> src/rpsm_checker.sv
// Port-level checker for the RTSP payload signature matcher, bound to the top level.
// Depends only on the top level's ports.

module rpsm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_match
);

	// Final beats accepted whose verdicts have not yet been taken.
	logic [1:0] pending_q;
	logic       inc;
	logic       dec;

	assign inc = in_valid && in_ready && in_last;
	assign dec = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (inc && !dec) begin
			pending_q <= pending_q + 2'd1;
		end else if (dec && !inc) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict dropped while stalled");

	a_match_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_match))
		else $error("verdict changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("verdict without a final beat");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more verdicts in flight than the block can hold");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

endmodule

bind rtsp_payload_signature_matcher rpsm_checker u_rpsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (payload.valid),
	.in_ready  (payload.ready),
	.in_last   (payload.last_byte),
	.out_valid (verdict.valid),
	.out_ready (verdict.ready),
	.out_match (verdict.rtsp_match)
);

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the RTSP payload signature matcher.
// Drives rtsp_payload_signature_matcher through rpsm_in_if and rpsm_out_if;
// needs only the RTL sources.

module tb;

	localparam int NUM_SIG_WORDS = 12;
	localparam int SIG_WORD_MAX  = 14;
	localparam int WORD_TD       = 10;
	localparam int WORD_RESP     = 11;

	// Matcher phases beyond the literal-word positions.
	localparam logic [5:0] PH_TEARDOWN = 6'd62;
	localparam logic [5:0] PH_RESPONSE = 6'd63;

	// How the directed table gives the verdict of its final beats.
	localparam logic [1:0] WANT_NO    = 2'd0;
	localparam logic [1:0] WANT_YES   = 2'd1;
	localparam logic [1:0] WANT_MODEL = 2'd2;

	localparam logic VAR_UDP = 1'b0;
	localparam logic VAR_TCP = 1'b1;

	localparam int NUM_PHASES  = 6;
	localparam int PHASE_BEATS = 185;
	localparam int HOLD_START  = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 4;
	localparam int LIMIT       = 100000;

	logic clk = 1'b0;
	logic arst_n;
	logic variant_we;
	logic variant_wdata;
	logic sink_rdy;
	logic hold_active;

	rpsm_in_if  pay_if ();
	rpsm_out_if ver_if ();

	// The receiver's ready is its own per-beat choice, masked by the long hold-off.
	assign ver_if.ready = sink_rdy & ~hold_active;

	rtsp_payload_signature_matcher DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.payload       (pay_if),
		.verdict       (ver_if),
		.variant_we    (variant_we),
		.variant_wdata (variant_wdata)
	);

	always #2 clk = ~clk;

	// Predictor state: a copy of the matcher's DFA and its variant register.
	logic       tb_variant;
	logic [5:0] sig_phase;
	logic [3:0] sig_word;
	logic [3:0] sig_prog;
	logic [1:0] sig_dwin;
	logic       sig_ended;
	logic       sig_matched;
	logic       sig_rejected;

	bit         expected_verdicts[$];
	logic [1:0] beat_wants[$];
	logic [7:0] pl[$];
	int         err_cnt   = 0;
	int         beats_in  = 0;
	int         cycle_cnt = 0;
	bit         in_steady  = 1'b0;
	bit         out_steady = 1'b0;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
		logic       tcp;
		logic [1:0] want;
	} beat_row_t;

	// Directed beats. A verdict is typed in only where it is obvious; the rest go
	// through the predictor.
	localparam int NUM_ROWS = 25;
	beat_row_t dir_rows [NUM_ROWS] = '{
		'{8'hFF, 1'b1, 1'b1, VAR_UDP, WANT_NO},    // zero-length payload
		'{"P",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"L",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"A",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"Y",   1'b1, 1'b0, VAR_UDP, WANT_YES},   // bare method name
		'{8'h00, 1'b1, 1'b0, VAR_UDP, WANT_NO},    // a lone zero byte
		'{"P",   1'b0, 1'b1, VAR_UDP, WANT_MODEL}, // empty flag on a middle beat
		'{"A",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{8'h00, 1'b0, 1'b0, VAR_UDP, WANT_MODEL}, // string ends here
		'{"U",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"S",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"E",   1'b1, 1'b0, VAR_UDP, WANT_NO},
		'{"P",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"L",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"A",   1'b0, 1'b0, VAR_UDP, WANT_MODEL},
		'{"Y",   1'b0, 1'b0, VAR_UDP, WANT_MODEL}, // matched before the end
		'{8'hFF, 1'b1, 1'b0, VAR_UDP, WANT_YES},
		'{8'h0A, 1'b1, 1'b0, VAR_UDP, WANT_NO},
		'{"P",   1'b0, 1'b0, VAR_TCP, WANT_MODEL},
		'{"A",   1'b0, 1'b0, VAR_TCP, WANT_MODEL},
		'{"U",   1'b0, 1'b0, VAR_TCP, WANT_MODEL},
		'{"S",   1'b0, 1'b0, VAR_TCP, WANT_MODEL},
		'{"E",   1'b1, 1'b0, VAR_TCP, WANT_YES},
		'{"R",   1'b1, 1'b0, VAR_TCP, WANT_NO},    // prefix of a word only
		'{8'h80, 1'b1, 1'b0, VAR_TCP, WANT_NO}
	};

	function automatic string sig_word_text(input int w);
		string pm;
		pm = "PARAMETER";
		case (w)
			0:       return "DESCRIBE";
			1:       return "ANNOUNCE";
			2:       return {"GET_", pm};
			3:       return "OPTIONS";
			4:       return "PAUSE";
			5:       return "PLAY";
			6:       return "RECORD";
			7:       return "REDIRECT";
			8:       return "SETUP";
			9:       return {"SET_", pm};
			10:      return "TEARDOWN ";
			default: return "RTSP/";
		endcase
	endfunction

	function automatic bit dec_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	// Every verdict returns the DFA to the start of the anchored pattern.
	task automatic clear_sig_state();
		sig_phase    = '0;
		sig_word     = '0;
		sig_prog     = '0;
		sig_dwin     = '0;
		sig_ended    = 1'b0;
		sig_matched  = 1'b0;
		sig_rejected = 1'b0;
	endtask

	// Advances the predicted DFA by one accepted beat and tells whether that beat
	// produces a verdict, and which.
	task automatic advance_signature(input logic [7:0] c, input logic lst, input logic emp,
			output bit has_v, output bit v);
		int    pos;
		int    cur;
		int    hit;
		int    w;
		int    k;
		bit    agree;
		bit    ok;
		string ws;
		string cs;
		logic [3:0] restart;
		has_v = 1'b0;
		v     = 1'b0;
		if (lst && emp) begin
			has_v = 1'b1;
			clear_sig_state();
			return;
		end
		restart = (c == " ") ? 4'd1 : 4'd0;
		if (!(sig_ended || sig_matched || sig_rejected)) begin
			if (c == 8'h00) begin
				sig_ended = 1'b1;
			end else if (sig_phase == PH_TEARDOWN) begin
				// Unanchored search for " RTSP/" digit(s) "." digit.
				if (sig_prog < 4'd6) begin
					cs = " RTSP/";
					sig_prog = (cs[sig_prog] == c) ? sig_prog + 4'd1 : restart;
				end else if (sig_prog == 4'd6) begin
					sig_prog = dec_digit(c) ? 4'd7 : restart;
				end else if (sig_prog == 4'd7) begin
					if (c == ".")
						sig_prog = 4'd8;
					else if (tb_variant == VAR_UDP && dec_digit(c))
						sig_prog = 4'd7;
					else
						sig_prog = restart;
				end else begin
					if (dec_digit(c))
						sig_matched = 1'b1;
					else
						sig_prog = restart;
				end
			end else if (sig_phase == PH_RESPONSE && tb_variant == VAR_UDP) begin
				// Strict: digits "." digits " " status " ".
				ok = 1'b0;
				case (sig_prog)
					4'd0: begin ok = dec_digit(c); if (ok) sig_prog = 4'd1; end
					4'd1: begin
						ok = dec_digit(c) || c == ".";
						if (c == ".") sig_prog = 4'd2;
					end
					4'd2: begin ok = dec_digit(c); if (ok) sig_prog = 4'd3; end
					4'd3: begin
						ok = dec_digit(c) || c == " ";
						if (c == " ") sig_prog = 4'd4;
					end
					4'd4: begin ok = (c >= "1") && (c <= "5"); if (ok) sig_prog = 4'd5; end
					4'd5: begin ok = dec_digit(c); if (ok) sig_prog = 4'd6; end
					4'd6: begin ok = dec_digit(c); if (ok) sig_prog = 4'd7; end
					default: begin ok = (c == " "); if (ok) sig_matched = 1'b1; end
				endcase
				if (!ok) sig_rejected = 1'b1;
			end else if (sig_phase == PH_RESPONSE) begin
				// Loose: digit "." digit, then a status code anywhere later.
				if (sig_prog == 4'd0) begin
					if (dec_digit(c)) sig_prog = 4'd1; else sig_rejected = 1'b1;
				end else if (sig_prog == 4'd1) begin
					if (c == ".") sig_prog = 4'd2; else sig_rejected = 1'b1;
				end else if (sig_prog == 4'd2) begin
					if (dec_digit(c)) begin
						sig_prog = 4'd3;
						sig_dwin = 2'd0;
					end else begin
						sig_rejected = 1'b1;
					end
				end else if (sig_dwin == 2'd0) begin
					sig_dwin = (c >= "1" && c <= "5") ? 2'd1 : 2'd0;
				end else if (sig_dwin == 2'd1) begin
					sig_dwin = dec_digit(c) ? 2'd2 : 2'd0;
				end else begin
					if (dec_digit(c)) sig_matched = 1'b1; else sig_dwin = 2'd0;
				end
			end else begin
				// Literal prefix: the first word that agrees with all bytes so far
				// and with this one.
				pos = sig_phase;
				cur = (sig_word < NUM_SIG_WORDS) ? sig_word : 0;
				hit = -1;
				if (pos >= SIG_WORD_MAX) begin
					sig_rejected = 1'b1;
				end else begin
					cs = sig_word_text(cur);
					for (w = 0; w < NUM_SIG_WORDS; w++) begin
						if (hit < 0) begin
							ws = sig_word_text(w);
							agree = (pos < ws.len()) && (ws[pos] == c);
							if (agree)
								for (k = 0; k < pos; k++)
									if (ws[k] != cs[k]) agree = 1'b0;
							if (agree) hit = w;
						end
					end
					if (hit < 0) begin
						sig_rejected = 1'b1;
					end else begin
						ws = sig_word_text(hit);
						sig_word  = 4'(hit);
						sig_phase = 6'(pos + 1);
						if (pos + 1 == ws.len()) begin
							sig_prog = '0;
							sig_dwin = '0;
							if (hit == WORD_TD)
								sig_phase = PH_TEARDOWN;
							else if (hit == WORD_RESP)
								sig_phase = PH_RESPONSE;
							else
								sig_matched = 1'b1;
						end
					end
				end
			end
		end
		if (lst) begin
			has_v = 1'b1;
			v     = sig_matched;
			clear_sig_state();
		end
	endtask

	task automatic note_error(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Scoreboard: verdicts leaving the block are checked first, then the beat that
	// enters at the same edge is run through the predictor. A register write seen
	// at this edge takes effect for the following beats.
	always @(posedge clk) begin
		bit         has_v;
		bit         v;
		bit         want_v;
		logic [1:0] want;
		if (arst_n) begin
			if (ver_if.valid && ver_if.ready) begin
				if (expected_verdicts.size() == 0) begin
					note_error($sformatf("verdict %0b with none expected", ver_if.rtsp_match));
				end else begin
					want_v = expected_verdicts.pop_front();
					if (ver_if.rtsp_match !== want_v)
						note_error($sformatf("rtsp_match %b, expected %0b",
							ver_if.rtsp_match, want_v));
				end
			end
			if (pay_if.valid && pay_if.ready) begin
				want = beat_wants.pop_front();
				advance_signature(pay_if.payload_byte, pay_if.last_byte,
					pay_if.empty_payload, has_v, v);
				if (has_v)
					expected_verdicts.push_back((want == WANT_MODEL) ? v : want[0]);
				beats_in++;
			end
			if (variant_we)
				tb_variant = variant_wdata;
		end
	end

	// Run limit, far above the slowest legal run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver: a random stall before each verdict, with runs of no stalls at all.
	initial begin
		int stall;
		sink_rdy <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = out_steady ? 0 : $urandom_range(0, 7);
			if (stall != 0) begin
				sink_rdy <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			sink_rdy <= 1'b1;
			do @(posedge clk); while (!(ver_if.valid && ver_if.ready));
			if ($urandom_range(0, 11) == 0) out_steady = ~out_steady;
		end
	end

	// One long hold-off on the verdict side while the sender keeps going, so that
	// a final byte backs up behind the held verdict and the input stalls.
	initial begin
		hold_active <= 1'b0;
		wait (beats_in >= HOLD_START);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// Offers one beat after a random gap and returns at the edge that accepts it.
	// With no gap, valid simply stays high into the next beat.
	task automatic send_beat(input logic [7:0] b, input logic lst, input logic emp,
			input logic [1:0] want);
		int gap;
		gap = in_steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			pay_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat_wants.push_back(want);
		pay_if.valid         <= 1'b1;
		pay_if.payload_byte  <= b;
		pay_if.last_byte     <= lst;
		pay_if.empty_payload <= emp;
		do @(posedge clk); while (!pay_if.ready);
	endtask

	// Lets every pending verdict come out, waits out the pipeline, then writes
	// the variant register while the block is idle. The first edge makes sure
	// the scoreboard has seen the last accepted beat.
	task automatic settle_and_write(input logic val);
		pay_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		variant_we    <= 1'b1;
		variant_wdata <= val;
		@(posedge clk);
		variant_we    <= 1'b0;
	endtask

	task automatic put_str(input string s);
		int k;
		for (k = 0; k < s.len(); k++) pl.push_back(s[k]);
	endtask

	task automatic put_digits(input int n);
		repeat (n) pl.push_back(8'(8'h30 + $urandom_range(0, 9)));
	endtask

	// Wildcard filler: spaces and 'R' to tease the literal search, otherwise any
	// nonzero byte, newlines and high bytes included.
	task automatic put_filler(input int n);
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 2);
			if (pick == 0)
				pl.push_back(" ");
			else if (pick == 1)
				pl.push_back("R");
			else
				pl.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	task automatic put_status();
		if ($urandom_range(0, 5) == 0)
			pl.push_back(8'(8'h30 + $urandom_range(0, 9)));
		else
			pl.push_back(8'(8'h30 + $urandom_range(1, 5)));
		put_digits(2);
	endtask

	// Builds one random payload in pl. Most are well formed for either variant;
	// some are cut-off words and pure noise, and a share get one byte overwritten
	// or the tail chopped off.
	task automatic build_payload(input logic tcp);
		int    kind;
		int    n;
		string ws;
		pl.delete();
		kind = $urandom_range(0, 8);
		case (kind)
			0, 1: begin
				put_str(sig_word_text($urandom_range(0, 9)));
				put_filler($urandom_range(0, 4));
			end
			2, 3: begin
				put_str(sig_word_text(WORD_TD));
				put_filler($urandom_range(0, 5));
				put_str(" RTSP/");
				put_digits($urandom_range(1, 2));
				pl.push_back(".");
				put_digits($urandom_range(1, 2));
				put_filler($urandom_range(0, 3));
			end
			4, 5, 6: begin
				put_str(sig_word_text(WORD_RESP));
				put_digits($urandom_range(1, 2));
				pl.push_back(".");
				put_digits($urandom_range(1, 2));
				// Mostly the layout of the selected variant, sometimes the other.
				if (($urandom_range(0, 3) == 0) ? !tcp : tcp) begin
					put_filler($urandom_range(0, 4));
					put_status();
				end else begin
					pl.push_back(" ");
					put_status();
					pl.push_back(" ");
				end
				put_filler($urandom_range(0, 3));
			end
			7: begin
				ws = sig_word_text($urandom_range(0, NUM_SIG_WORDS - 1));
				put_str(ws.substr(0, $urandom_range(0, ws.len() - 2)));
			end
			default: begin
				repeat ($urandom_range(1, 6)) pl.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		if ($urandom_range(0, 4) == 0)
			pl[$urandom_range(0, pl.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(1, pl.size());
			while (pl.size() > n) void'(pl.pop_back());
		end
	endtask

	initial begin
		int   r;
		int   ph;
		int   i;
		int   sent;
		logic cur_var;
		logic lst;
		pay_if.valid         <= 1'b0;
		pay_if.payload_byte  <= 8'h00;
		pay_if.last_byte     <= 1'b0;
		pay_if.empty_payload <= 1'b0;
		variant_we           <= 1'b0;
		variant_wdata        <= 1'b0;
		arst_n               <= 1'b0;
		tb_variant = VAR_UDP;
		clear_sig_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; the variant is switched only between payloads, once
		// the block has gone idle.
		cur_var = VAR_UDP;
		for (r = 0; r < NUM_ROWS; r++) begin
			if (dir_rows[r].tcp != cur_var) begin
				cur_var = dir_rows[r].tcp;
				settle_and_write(cur_var);
			end
			send_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].empty,
				dir_rows[r].want);
		end

		// Random phases alternate between the two variants.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			cur_var = (ph % 2 == 0) ? VAR_UDP : VAR_TCP;
			settle_and_write(cur_var);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 9) == 0) in_steady = ~in_steady;
				if ($urandom_range(0, 24) == 0) begin
					send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, WANT_MODEL);
					sent++;
				end else begin
					build_payload(cur_var);
					for (i = 0; i < pl.size(); i++) begin
						lst = (i == pl.size() - 1);
						send_beat(pl[i], lst,
							!lst && ($urandom_range(0, 15) == 0), WANT_MODEL);
					end
					sent += pl.size();
				end
			end
		end

		pay_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
